// ----- sv/utf8_to_utf16_validating_transcoder_macros.svh -----
// Assertion macros used by the transcoder's checker
`ifndef UTF8_TO_UTF16_VALIDATING_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_VALIDATING_TRANSCODER_MACROS_SVH

// Same-cycle implication, held off while reset is low
`define U2U_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low
`define U2U_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/u2u_pkg.sv -----
// Types, constants and helper functions of the UTF-8 to UTF-16 transcoder
package u2u_pkg;

    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam logic [20:0] MAX_POINT   = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST  = 21'h00D800;
    localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
    localparam logic [20:0] PLANE1_BASE = 21'h010000;
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;
    localparam logic [1:0]  CONT_TAG    = 2'b10;

    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam int MAX_UNITS = 4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
        logic        run_end;
        logic        text_end;
    } t_out_beat;

    // All units produced by one input byte
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] unit;
        logic [MAX_UNITS-1:0]       rep;
        logic [2:0]                 cnt;
        logic                       fin;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Sequence length from a lead byte; stray bytes count as length one
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd1;
        if (b[7] == 1'b0)            len = 3'd1;
        else if (b[7:5] == 3'b110)   len = 3'd2;
        else if (b[7:4] == 4'b1110)  len = 3'd3;
        else if (b[7:3] == 5'b11110) len = 3'd4;
        return len;
    endfunction

    // Assemble a code point from the held bytes and the closing byte
    function automatic logic [20:0] decode(input logic [7:0] h0, input logic [7:0] h1,
                                           input logic [7:0] h2, input logic [7:0] last,
                                           input logic [2:0] exp_len);
        logic [20:0] cp;
        if (exp_len <= 3'd2)
            cp = {10'd0, h0[4:0], last[5:0]};
        else if (exp_len == 3'd3)
            cp = {5'd0, h0[3:0], h1[5:0], last[5:0]};
        else
            cp = {h0[2:0], h1[5:0], h2[5:0], last[5:0]};
        return cp;
    endfunction

endpackage

// ----- sv/u2u_front.sv -----
// Front end: holds the open sequence and turns each byte into a job of units
module u2u_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  u2u_pkg::t_in_beat i_data,
    input  logic              i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output u2u_pkg::t_job     o_job
);

    logic [7:0] r_held [3];
    logic [7:0] n_held [3];
    logic [1:0] r_cnt, n_cnt;
    logic [2:0] r_exp, n_exp;

    logic                              w_acc;
    logic [7:0]                        w_b;
    logic                              w_cont;
    logic                              w_lead;
    logic [2:0]                        w_len;
    logic [20:0]                       w_cp;
    logic [20:0]                       w_v;
    logic [u2u_pkg::MAX_UNITS-1:0][15:0] w_unit;
    logic [u2u_pkg::MAX_UNITS-1:0]     w_rep;
    logic [2:0]                        w_n;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;
    assign w_b     = i_data.text_byte;
    assign w_cont  = (w_b[7:6] == u2u_pkg::CONT_TAG);
    assign w_len   = u2u_pkg::lead_len(w_b);
    assign w_cp    = u2u_pkg::decode(r_held[0], r_held[1], r_held[2], w_b, r_exp);
    assign w_v     = w_cp - u2u_pkg::PLANE1_BASE;

    always_comb begin
        n_held = r_held;
        n_cnt  = r_cnt;
        n_exp  = r_exp;
        w_unit = '0;
        w_rep  = '0;
        w_n    = '0;
        w_lead = (r_cnt == 2'd0) || !w_cont;

        if (r_cnt != 2'd0 && w_cont) begin
            if ((({1'b0, r_cnt} + 3'd1) >= r_exp) || (r_cnt == 2'd3)) begin
                // sequence complete: emit the code point, or U+FFFD if out of range or a surrogate
                if (w_cp > u2u_pkg::MAX_POINT ||
                    (w_cp >= u2u_pkg::SURR_FIRST && w_cp <= u2u_pkg::SURR_LAST)) begin
                    w_unit[w_n[1:0]] = u2u_pkg::REPL_UNIT;
                    w_rep[w_n[1:0]]  = 1'b1;
                    w_n              = w_n + 3'd1;
                end else if (w_cp >= u2u_pkg::PLANE1_BASE) begin
                    w_unit[w_n[1:0]] = {u2u_pkg::HI_SURR_TAG, w_v[19:10]};
                    w_n              = w_n + 3'd1;
                    w_unit[w_n[1:0]] = {u2u_pkg::LO_SURR_TAG, w_v[9:0]};
                    w_n              = w_n + 3'd1;
                end else begin
                    w_unit[w_n[1:0]] = w_cp[15:0];
                    w_n              = w_n + 3'd1;
                end
                n_cnt = 2'd0;
                n_exp = 3'd0;
            end else begin
                n_held[r_cnt] = w_b;
                n_cnt         = r_cnt + 2'd1;
            end
        end else if (r_cnt != 2'd0) begin
            // broken sequence: replace the lead, pass continuations by value
            w_unit[w_n[1:0]] = u2u_pkg::REPL_UNIT;
            w_rep[w_n[1:0]]  = 1'b1;
            w_n              = w_n + 3'd1;
            for (int k = 1; k < 3; k++) begin
                if (k < int'(r_cnt)) begin
                    w_unit[w_n[1:0]] = {8'd0, r_held[k]};
                    w_n              = w_n + 3'd1;
                end
            end
            n_cnt = 2'd0;
            n_exp = 3'd0;
        end

        if (w_lead) begin
            if (w_len == 3'd1) begin
                w_unit[w_n[1:0]] = {8'd0, w_b};
                w_n              = w_n + 3'd1;
            end else begin
                n_held[0] = w_b;
                n_cnt     = 2'd1;
                n_exp     = w_len;
            end
        end

        if (i_data.final_byte && n_cnt != 2'd0) begin
            // end of text mid-sequence: flush what is held
            w_unit[w_n[1:0]] = u2u_pkg::REPL_UNIT;
            w_rep[w_n[1:0]]  = 1'b1;
            w_n              = w_n + 3'd1;
            for (int k = 1; k < 3; k++) begin
                if (k < int'(n_cnt)) begin
                    w_unit[w_n[1:0]] = {8'd0, n_held[k]};
                    w_n              = w_n + 3'd1;
                end
            end
            n_cnt = 2'd0;
            n_exp = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_exp <= '0;
        end else if (w_acc) begin
            r_cnt <= n_cnt;
            r_exp <= n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_held <= n_held;
        end
    end

    assign o_push    = w_acc && (w_n != 3'd0);
    assign o_job.unit = w_unit;
    assign o_job.rep  = w_rep;
    assign o_job.cnt  = w_n;
    assign o_job.fin  = i_data.final_byte;

endmodule

// ----- sv/u2u_queue.sv -----
// Short job queue between the front end and the unit serialiser
module u2u_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  u2u_pkg::t_job       i_job,
    input  logic                i_pop,
    output u2u_pkg::t_job       o_head,
    output u2u_pkg::t_q_status  o_status
);

    u2u_pkg::t_job r_mem [u2u_pkg::QDEPTH];

    logic [u2u_pkg::QAW-1:0] r_wp, r_rp;
    logic [u2u_pkg::QAW:0]   r_count;

    function automatic logic [u2u_pkg::QAW-1:0] bump(input logic [u2u_pkg::QAW-1:0] p);
        logic [u2u_pkg::QAW-1:0] q;
        if (p == u2u_pkg::QAW'(u2u_pkg::QDEPTH - 1))
            q = '0;
        else
            q = p + 1'b1;
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= bump(r_wp);
            if (i_pop)  r_rp <= bump(r_rp);
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_head         = r_mem[r_rp];
    assign o_status.full  = (r_count == (u2u_pkg::QAW + 1)'(u2u_pkg::QDEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ----- sv/u2u_back.sv -----
// Back end: issue the units of the head job one beat at a time
module u2u_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u2u_pkg::t_job       i_head,
    input  logic                i_head_valid,
    input  logic                i_ready,
    output logic                o_valid,
    output u2u_pkg::t_out_beat  o_data,
    output logic                o_pop
);

    logic [1:0] r_idx;
    logic       w_last;
    logic       w_acc;

    assign w_last  = (({1'b0, r_idx} + 3'd1) == i_head.cnt);
    assign o_valid = i_head_valid;
    assign w_acc   = o_valid && i_ready;
    assign o_pop   = w_acc && w_last;

    assign o_data.code_unit = i_head.unit[r_idx];
    assign o_data.replaced  = i_head.rep[r_idx];
    assign o_data.run_end   = w_last;
    assign o_data.text_end  = w_last && i_head.fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_pop) begin
            r_idx <= '0;
        end else if (w_acc) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// ----- sv/utf8_to_utf16_validating_transcoder.sv -----
// Top level of the UTF-8 to UTF-16 transcoder with bad-input substitution
//
//  Channel | Direction | Handshake                   | Beat
//  --------+-----------+-----------------------------+--------------------------------------
//  in      | sink      | i_in_valid / o_in_ready     | one UTF-8 byte plus end-of-text flag
//  out     | source    | o_out_valid / i_out_ready   | one UTF-16 unit with run/text markers
//
//  Each input beat is classified combinationally; a beat produces zero to four output
//  beats, issued one per cycle while the output is ready to take them.
//  The front end takes a new byte every cycle while the two-entry job queue has room.
//  Reset (synchronous, active low) empties the queue and drops any open sequence.
//  An output stall backs up into the queue; the input stalls only once it is full.
module utf8_to_utf16_validating_transcoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  u2u_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output u2u_pkg::t_out_beat  o_out_data
);

    // job handed from the front end to the queue
    logic               w_push;
    u2u_pkg::t_job      w_job;

    // queue head and status seen by the back end
    u2u_pkg::t_job      w_head;
    u2u_pkg::t_q_status w_q_stat;
    logic               w_pop;

    // Front end: decode bytes, hold open sequences, build jobs
    u2u_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_data   (i_in_data),
        .i_q_full (w_q_stat.full),
        .o_ready  (o_in_ready),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    // Decouple the two sides so an output stall does not block decode at once
    u2u_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_job),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_stat)
    );

    // Back end: walk the head job unit by unit, drop it after its last beat
    u2u_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (!w_q_stat.empty),
        .i_ready      (i_out_ready),
        .o_valid      (o_out_valid),
        .o_data       (o_out_data),
        .o_pop        (w_pop)
    );

endmodule

// ----- sv/u2u_checker.sv -----
// Port-level checker for the transcoder, bound to the top level
`include "utf8_to_utf16_validating_transcoder_macros.svh"

module u2u_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input u2u_pkg::t_in_beat   i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input u2u_pkg::t_out_beat  o_out_data
);

    `U2U_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "output beat changed while stalled")

    `U2U_ASSERT_IMP(a_text_end_run, i_clk, i_rst_n, o_out_valid && o_out_data.text_end, o_out_data.run_end, "text end without run end")

    `U2U_ASSERT_IMP(a_repl_value, i_clk, i_rst_n, o_out_valid && o_out_data.replaced, o_out_data.code_unit == u2u_pkg::REPL_UNIT, "substituted unit is not U+FFFD")

    `U2U_ASSERT_IMP(a_hi_surr_pair, i_clk, i_rst_n, o_out_valid && o_out_data.code_unit[15:10] == u2u_pkg::HI_SURR_TAG, !o_out_data.run_end && !o_out_data.replaced, "high surrogate closes a run")

endmodule

bind utf8_to_utf16_validating_transcoder u2u_checker u_chk (.*);
